[sv/tal_pkg.sv]
// tal_pkg: shared types and constants for the timed actuator with limit stop
// no dependencies; used by the channel interfaces and the core
package tal_pkg;

   localparam int CMD_W        = 2;
   localparam int SPEED_W      = 8;
   localparam int DURATION_W   = 32;
   localparam int SAMPLE_W     = 10;
   localparam int MOTION_W     = 2;
   localparam int SAMPLE_FIELDS = 5;

   localparam int NUM_SAMPLES_DEF = 5;
   localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 10'd1022;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_UP    = 2'd1,
      CMD_DOWN  = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   typedef enum logic [MOTION_W-1:0] {
      MOT_IDLE = 2'd0,
      MOT_UP   = 2'd1,
      MOT_DOWN = 2'd2
   } motion_type;

endpackage

[sv/tal_if.sv]
// tal_if: valid/ready channel interfaces for command words and result words
// depends on tal_pkg for field widths
interface tal_req_if;
   logic                                valid;
   logic                                ready;
   logic [tal_pkg::CMD_W-1:0]           cmd;
   logic [tal_pkg::SPEED_W-1:0]         speed;
   logic [tal_pkg::DURATION_W-1:0]      duration;
   logic [tal_pkg::SAMPLE_W-1:0]        limit_sample_0;
   logic [tal_pkg::SAMPLE_W-1:0]        limit_sample_1;
   logic [tal_pkg::SAMPLE_W-1:0]        limit_sample_2;
   logic [tal_pkg::SAMPLE_W-1:0]        limit_sample_3;
   logic [tal_pkg::SAMPLE_W-1:0]        limit_sample_4;

   modport source (
      output valid, cmd, speed, duration,
      output limit_sample_0, limit_sample_1, limit_sample_2, limit_sample_3, limit_sample_4,
      input  ready
   );
   modport sink (
      input  valid, cmd, speed, duration,
      input  limit_sample_0, limit_sample_1, limit_sample_2, limit_sample_3, limit_sample_4,
      output ready
   );
endinterface

interface tal_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                dir_a;
   logic                                dir_b;
   logic [tal_pkg::SPEED_W-1:0]         pwm_duty;
   logic [tal_pkg::MOTION_W-1:0]        motion_state;
   logic                                limit_event;
   logic                                complete_event;
   logic                                start_refused;

   modport source (
      output valid, dir_a, dir_b, pwm_duty, motion_state,
      output limit_event, complete_event, start_refused,
      input  ready
   );
   modport sink (
      input  valid, dir_a, dir_b, pwm_duty, motion_state,
      input  limit_event, complete_event, start_refused,
      output ready
   );
endinterface

[sv/timed_actuator_with_limit_stop_core.sv]
// timed_actuator_with_limit_stop_core: H-bridge drive sequencer with timed moves and limit stop
// depends on tal_pkg and the channel interfaces in tal_if
//
//   port    dir   handshake      contents
//   req     in    valid/ready    cmd, speed, duration, limit_sample_0..4
//   rsp     out   valid/ready    dir_a, dir_b, pwm_duty, motion_state, events
//   csr_*   in    write enable   limit level for the sample average
//
// one word per cycle sustained while rsp is not stalled; each word passes through
// the input register, then the state update and result register, before its
// result word is shown with rsp valid
// the motion state is updated as a word leaves the input register, so words
// issued back to back see each other's effect
// a stalled rsp holds both stages; req.ready drops only when both are full
// reset is synchronous: motion idle, counters zero, threshold 1022
module timed_actuator_with_limit_stop_core #(
   parameter int NUM_SAMPLES = tal_pkg::NUM_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tal_req_if.sink                       req,
   tal_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [tal_pkg::SAMPLE_W-1:0]  csr_wdata
);

   // only five sample fields exist, so the count is clamped to 1..5
   localparam int USED  = (NUM_SAMPLES > tal_pkg::SAMPLE_FIELDS) ? tal_pkg::SAMPLE_FIELDS :
                          ((NUM_SAMPLES < 1) ? 1 : NUM_SAMPLES);
   localparam int SUM_W = $clog2(USED * (1 << tal_pkg::SAMPLE_W) + 1);
   localparam logic [SUM_W-1:0] USED_V = SUM_W'(USED);

   // threshold register
   logic [tal_pkg::SAMPLE_W-1:0]   thr_ff;

   // input stage
   logic                           s1_valid_ff;
   tal_pkg::cmd_type               s1_cmd_ff;
   logic [tal_pkg::SPEED_W-1:0]    s1_speed_ff;
   logic [tal_pkg::DURATION_W-1:0] s1_duration_ff;
   logic [SUM_W-1:0]               s1_sum_ff;

   // actuator state
   tal_pkg::motion_type            motion_ff, motion_in;
   logic [tal_pkg::SPEED_W-1:0]    drive_speed_ff, drive_speed_in;
   logic [tal_pkg::DURATION_W-1:0] elapsed_ff, elapsed_in;
   logic [tal_pkg::DURATION_W-1:0] move_len_ff, move_len_in;

   // result register
   logic                           rsp_valid_ff;
   logic [tal_pkg::SPEED_W-1:0]    rsp_duty_ff;
   tal_pkg::motion_type            rsp_motion_ff;
   logic                           rsp_lim_ff, rsp_done_ff, rsp_refused_ff;

   logic                           out_free;
   logic                           s1_adv;
   logic                           req_fire;
   logic [tal_pkg::SAMPLE_W-1:0]   samples [tal_pkg::SAMPLE_FIELDS];
   logic [SUM_W-1:0]               sum_in;
   logic [SUM_W-1:0]               limit_bound;
   logic                           at_limit;
   logic [tal_pkg::DURATION_W-1:0] elapsed_inc;
   logic                           lim_ev, done_ev, refused;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_fire  = req.valid && req.ready;

   assign samples[0] = req.limit_sample_0;
   assign samples[1] = req.limit_sample_1;
   assign samples[2] = req.limit_sample_2;
   assign samples[3] = req.limit_sample_3;
   assign samples[4] = req.limit_sample_4;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < USED; i++) begin
         sum_in = sum_in + SUM_W'(samples[i]);
      end
   end

   // floor(sum / n) > thr  is the same as  sum >= n * (thr + 1)
   assign limit_bound = USED_V * (SUM_W'(thr_ff) + SUM_W'(1));
   assign at_limit    = (s1_sum_ff >= limit_bound);

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      motion_in      = motion_ff;
      drive_speed_in = drive_speed_ff;
      elapsed_in     = elapsed_ff;
      move_len_in    = move_len_ff;
      lim_ev         = 1'b0;
      done_ev        = 1'b0;
      refused        = 1'b0;
      case (s1_cmd_ff)
         tal_pkg::CMD_TICK: begin
            elapsed_in = elapsed_inc;
            if (motion_ff == tal_pkg::MOT_UP && at_limit) begin
               motion_in      = tal_pkg::MOT_IDLE;
               drive_speed_in = '0;
               lim_ev         = 1'b1;
            end else if (motion_ff != tal_pkg::MOT_IDLE && elapsed_inc >= move_len_ff) begin
               motion_in      = tal_pkg::MOT_IDLE;
               drive_speed_in = '0;
               done_ev        = 1'b1;
            end
         end
         tal_pkg::CMD_UP: begin
            if (at_limit) begin
               motion_in      = tal_pkg::MOT_IDLE;
               drive_speed_in = '0;
               refused        = 1'b1;
            end else begin
               motion_in      = tal_pkg::MOT_UP;
               drive_speed_in = s1_speed_ff;
               elapsed_in     = '0;
               move_len_in    = s1_duration_ff;
            end
         end
         tal_pkg::CMD_DOWN: begin
            motion_in      = tal_pkg::MOT_DOWN;
            drive_speed_in = s1_speed_ff;
            elapsed_in     = '0;
            move_len_in    = s1_duration_ff;
         end
         tal_pkg::CMD_STOP: begin
            motion_in      = tal_pkg::MOT_IDLE;
            drive_speed_in = '0;
         end
         default: begin
            motion_in      = tal_pkg::MOT_IDLE;
            drive_speed_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= tal_pkg::LIMIT_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         motion_ff      <= tal_pkg::MOT_IDLE;
         drive_speed_ff <= '0;
         elapsed_ff     <= '0;
         move_len_ff    <= '0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_adv) begin
            motion_ff      <= motion_in;
            drive_speed_ff <= drive_speed_in;
            elapsed_ff     <= elapsed_in;
            move_len_ff    <= move_len_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff      <= tal_pkg::cmd_type'(req.cmd);
         s1_speed_ff    <= req.speed;
         s1_duration_ff <= req.duration;
         s1_sum_ff      <= sum_in;
      end
      if (s1_adv) begin
         rsp_duty_ff    <= drive_speed_in;
         rsp_motion_ff  <= motion_in;
         rsp_lim_ff     <= lim_ev;
         rsp_done_ff    <= done_ev;
         rsp_refused_ff <= refused;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.dir_a          = (rsp_motion_ff == tal_pkg::MOT_DOWN);
   assign rsp.dir_b          = (rsp_motion_ff == tal_pkg::MOT_UP);
   assign rsp.pwm_duty       = rsp_duty_ff;
   assign rsp.motion_state   = rsp_motion_ff;
   assign rsp.limit_event    = rsp_lim_ff;
   assign rsp.complete_event = rsp_done_ff;
   assign rsp.start_refused  = rsp_refused_ff;

   // at most one flag per result word
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_lim_ff, rsp_done_ff, rsp_refused_ff}))
      else $error("more than one event flag in a result word");

   // every event leaves the bridge off
   a_event_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_lim_ff || rsp_done_ff || rsp_refused_ff)) |->
      (rsp_motion_ff == tal_pkg::MOT_IDLE && rsp_duty_ff == '0))
      else $error("event reported while still driving");

   // idle state never carries a duty
   a_idle_no_duty: assert property (@(posedge clock) disable iff (reset)
      (motion_ff == tal_pkg::MOT_IDLE) |-> (drive_speed_ff == '0))
      else $error("duty held while idle");

   // the elapsed count only moves when a word is processed
   a_elapsed_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(s1_adv) |-> $stable(elapsed_ff))
      else $error("elapsed count changed without a word");

   // a held result word keeps its state fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_motion_ff)))
      else $error("stalled result word changed");

endmodule
